### hdl/lfia_pkg.sv
// Shared types and constants for the lowest-free id allocator.
// No dependencies; imported by lfia_word_unit, lowest_free_id_allocator_core and the test bench.
`default_nettype none

package lfia_pkg;

	localparam int ID_W         = 11;
	localparam int ID_FIELD_MAX = 2047;
	localparam int WORD_BITS    = 32;
	localparam int BIT_W        = 5;
	localparam int MAX_IDS_DEF  = 1024;

	typedef enum logic [1:0] {
		CMD_OPEN   = 2'd0,
		CMD_CLOSE  = 2'd1,
		CMD_WAIT   = 2'd2,
		CMD_SIGNAL = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [ID_W-1:0] event_id;
	} req_t;

	typedef struct packed {
		logic            ok;
		logic [ID_W-1:0] result_id;
	} rsp_t;

	// status of one bitmap word as seen by the shared word unit
	typedef struct packed {
		logic                 all_ones;
		logic                 bit_set;
		logic [BIT_W-1:0]     first_zero;
		logic [WORD_BITS-1:0] word_fz_set;
		logic [WORD_BITS-1:0] word_clr;
	} word_res_t;

endpackage

`default_nettype wire

### hdl/lfia_word_unit.sv
// Shared bitmap word unit: first-zero search, bit test, set and clear.
// Depends on lfia_pkg.
`default_nettype none

module lfia_word_unit
	import lfia_pkg::*;
(
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [BIT_W-1:0]     bit_sel,
	output word_res_t                 res
);

	logic [BIT_W-1:0] fz;

	// lowest clear bit; scanning down so the lowest index wins
	always_comb begin
		fz = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				fz = BIT_W'(i);
			end
		end
	end

	always_comb begin
		res.all_ones    = &word;
		res.bit_set     = word[bit_sel];
		res.first_zero  = fz;
		// x | (x + 1) sets the lowest clear bit
		res.word_fz_set = word | (word + WORD_BITS'(1));
		res.word_clr    = word & ~(WORD_BITS'(1) << bit_sel);
	end

endmodule

`default_nettype wire

### hdl/lowest_free_id_allocator_core.sv
// Lowest-free event id allocator, top level: sequencer, bitmap memory, result register.
// Depends on lfia_pkg and lfia_word_unit.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one transaction per command:
//   open with id 0 allocates the lowest free id; open, wait and signal with a
//   nonzero id check whether it is in use; close frees an id that is in use.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one transaction per
//   request: ok and the allocated or echoed id (0 when ok is low).
// Timing:
//   A lookup or close reads one bitmap word at acceptance; its result is
//   registered in the examine step once the result register is free. An
//   allocation scans one bitmap word per cycle through the shared word unit
//   until it finds a word with a clear bit or reaches the last of WORDS words
//   (32 at the default MAX_IDS). The sequencer then returns to idle, so a new
//   command is taken only after the previous result has been loaded.
//   req_stall is high while a command is in flight.
// Reset:
//   arst_n clears all in-use marks at once through per-word valid flags; the
//   bitmap RAM itself is not swept, and the block takes requests right away.
// Backpressure:
//   While rsp_stall holds a result, the next request may still be taken and
//   worked on; its result waits in the sequencer until the register drains.
`default_nettype none

module lowest_free_id_allocator_core
	import lfia_pkg::*;
#(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,

	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int WORDS  = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LIMIT  = (MAX_IDS > ID_FIELD_MAX) ? ID_FIELD_MAX : MAX_IDS;
	// wide enough for (last word, bit 31) + 1 and for the id field
	localparam int SID_W  = (WIDX_W + BIT_W + 1 > ID_W) ? WIDX_W + BIT_W + 1 : ID_W;

	typedef enum logic {
		ST_IDLE,
		ST_EXAM
	} state_t;

	state_t              state_q;
	logic                is_alloc_q;
	logic                is_close_q;
	logic                id_ok_q;
	logic [ID_W-1:0]     id_q;
	logic [BIT_W-1:0]    bit_q;
	logic [WIDX_W-1:0]   exam_addr_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// bitmap RAM plus per-word valid flags (invalid word reads as all clear)
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORDS-1:0]     word_valid_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvalid_q;
	logic [WIDX_W-1:0]    rd_addr;

	// request decode
	logic              accept;
	logic [ID_W-1:0]   pos;
	logic [31:0]       pos_ext;
	logic              range_ok;
	logic              req_alloc;
	logic [WIDX_W-1:0] start_addr;

	// examine stage
	logic [WORD_BITS-1:0] word;
	word_res_t            wres;
	logic [SID_W-1:0]     cand_id;
	logic                 done;
	logic                 cont;
	logic                 ok;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wdata;
	logic                 slot_free;
	logic                 load_rsp;
	logic [ID_W-1:0]      res_id;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	assign pos       = req.event_id - ID_W'(1);
	assign pos_ext   = {{(32 - ID_W){1'b0}}, pos};
	// id 0 and ids past the usable limit are never in use
	assign range_ok  = (req.event_id != '0) && (int'(req.event_id) <= LIMIT);
	assign req_alloc = (req.cmd == CMD_OPEN) && (req.event_id == '0);

	always_comb begin
		if (!req_alloc && range_ok) begin
			start_addr = pos_ext[BIT_W +: WIDX_W];
		end else begin
			start_addr = '0;
		end
	end

	assign word = rvalid_q ? rdata_q : '0;

	lfia_word_unit u_word (
		.word    (word),
		.bit_sel (bit_q),
		.res     (wres)
	);

	assign cand_id   = SID_W'({exam_addr_q, wres.first_zero}) + SID_W'(1);
	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		done  = 1'b0;
		cont  = 1'b0;
		ok    = 1'b0;
		wr_en = 1'b0;
		wdata = wres.word_clr;
		if (is_alloc_q) begin
			wdata = wres.word_fz_set;
			if (!wres.all_ones) begin
				// lowest free bit; beyond the limit means the table is full
				done = 1'b1;
				ok   = (cand_id <= SID_W'(LIMIT));
			end else if (exam_addr_q == WIDX_W'(WORDS - 1)) begin
				done = 1'b1;
			end else begin
				cont = 1'b1;
			end
		end else begin
			done = 1'b1;
			ok   = id_ok_q && wres.bit_set;
		end
		// only a close or a successful allocation changes the bitmap
		wr_en = (state_q == ST_EXAM) && done && slot_free && ok
			&& (is_alloc_q || is_close_q);
	end

	assign load_rsp = (state_q == ST_EXAM) && done && slot_free;
	assign res_id   = !ok ? '0 : (is_alloc_q ? cand_id[ID_W-1:0] : id_q);

	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = start_addr;
			ST_EXAM: rd_addr = (cont ? exam_addr_q + WIDX_W'(1) : exam_addr_q);
			default: rd_addr = exam_addr_q;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result may replace one that drains in the same cycle
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXAM;
					end
				end
				ST_EXAM: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command context and payloads, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			is_alloc_q  <= req_alloc;
			is_close_q  <= (req.cmd == CMD_CLOSE);
			id_ok_q     <= range_ok;
			id_q        <= req.event_id;
			bit_q       <= pos[BIT_W-1:0];
			exam_addr_q <= start_addr;
		end else if (state_q == ST_EXAM && cont) begin
			exam_addr_q <= exam_addr_q + WIDX_W'(1);
		end
		if (load_rsp) begin
			rsp_q.ok        <= ok;
			rsp_q.result_id <= res_id;
		end
	end

	// bitmap RAM: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[exam_addr_q] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= '0;
			rvalid_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				word_valid_q[exam_addr_q] <= 1'b1;
			end
			rvalid_q <= word_valid_q[rd_addr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a failed result never carries an id
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.ok || rsp.result_id == '0))
		else $error("failed result with nonzero id");

	// an accepted command always goes to the examine step
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXAM))
		else $error("accepted command not examined");

	// the bitmap is written only when a result is committed
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (load_rsp && ok))
		else $error("bitmap write without committed result");

	// a result is never loaded over one the receiver still holds
	assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |-> (!rsp_valid_q || !rsp_stall))
		else $error("result register overrun");

	// the scan pointer stays inside the bitmap
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXAM) |-> (int'(exam_addr_q) <= WORDS - 1))
		else $error("scan address out of range");

endmodule

`default_nettype wire

### sim/lowest_free_id_allocator_core_test.sv
// Self-checking bench for lowest_free_id_allocator_core: random and directed commands,
// replies checked against a behavioral id table kept by a small scoreboard class.
// Depends on lfia_pkg and the allocator RTL; nothing else.
`default_nettype none

module lowest_free_id_allocator_core_test;
	import lfia_pkg::*;

	localparam int TB_MAX_IDS = MAX_IDS_DEF;
	// ids above the 11-bit field cannot be handed out, so the table never goes past it
	localparam int ID_LIMIT   = (TB_MAX_IDS > ID_FIELD_MAX) ? ID_FIELD_MAX : TB_MAX_IDS;
	localparam int RANDOM_ITEMS = 1100;
	localparam int CHURN_ITEMS  = 50;
	localparam int REPORT_LIMIT = 10;

	// Behavioral id table plus the queue of replies still owed by the block.
	class id_table_scoreboard;
		bit          id_marks [ID_LIMIT+1];
		rsp_t        pending_replies [$];
		int unsigned mismatches;
		bit          table_filled;

		// Updates the marks for one command and returns the reply it must produce.
		function rsp_t apply_command(req_t item);
			rsp_t reply;
			int   id;
			int   probe;
			reply = '0;
			id    = item.event_id;
			if (item.cmd == CMD_OPEN && id == 0) begin
				probe = 1;
				while (probe <= ID_LIMIT && id_marks[probe])
					probe++;
				if (probe <= ID_LIMIT) begin
					id_marks[probe]  = 1'b1;
					reply.ok         = 1'b1;
					reply.result_id  = ID_W'(probe);
				end else begin
					table_filled = 1'b1;
				end
			end else if (id >= 1 && id <= ID_LIMIT && id_marks[id]) begin
				reply.ok        = 1'b1;
				reply.result_id = ID_W'(id);
				if (item.cmd == CMD_CLOSE)
					id_marks[id] = 1'b0;
			end
			return reply;
		endfunction

		function void note_command(req_t item);
			pending_replies.push_back(apply_command(item));
		endfunction

		function void flag_mismatch(string what, rsp_t want, rsp_t got);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s: expected ok=%0d id=%0d, got ok=%0d id=%0d", $time, what,
					want.ok, want.result_id, got.ok, got.result_id);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (pending_replies.size() == 0) begin
				flag_mismatch("reply with none owed", '0, got);
				return;
			end
			want = pending_replies.pop_front();
			if (got.ok !== want.ok)
				flag_mismatch("ok field", want, got);
			else if (got.result_id !== want.result_id)
				flag_mismatch("result_id field", want, got);
		endfunction

		function void check_leftovers();
			while (pending_replies.size() != 0)
				flag_mismatch("reply never came", pending_replies.pop_front(), '0);
		endfunction

		function int unsigned pending_count();
			return pending_replies.size();
		endfunction

		// Some id that is currently marked, found from a random start; 0 if none.
		function int find_busy_id();
			int start;
			int idx;
			int n;
			start = $urandom_range(1, ID_LIMIT);
			for (n = 0; n < ID_LIMIT; n++) begin
				idx = (start - 1 + n) % ID_LIMIT + 1;
				if (id_marks[idx])
					return idx;
			end
			return 0;
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	id_table_scoreboard table_sb;

	// idle odds per cycle, in percent; the stimulus moves these between phases
	int req_idle_pct = 17;
	int rsp_idle_pct = 53;
	// a nonzero value asks the reply side for a hold-off of that many cycles
	int hold_request = 0;

	lowest_free_id_allocator_core #(
		.MAX_IDS(TB_MAX_IDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offers one command and returns at the edge where it is taken. The prediction
	// is made right there, so the table the generator reads is always current.
	task automatic send_command(req_t item);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		table_sb.note_command(item);
	endtask

	task automatic issue(cmd_t cmd, int id);
		req_t item;
		item.cmd      = cmd;
		item.event_id = ID_W'(id);
		send_command(item);
	endtask

	// Sender goes quiet until every owed reply has come back.
	task automatic wait_for_drain();
		if (table_sb.pending_count() != 0) begin
			req_valid <= 1'b0;
			while (table_sb.pending_count() != 0)
				@(posedge clk);
		end
	endtask

	// Marked ids so checks and closes hit, as often in-range ids, plus full-field noise
	// (ids above the table come from the last arm, id zero from it or an empty table).
	function automatic int random_event_id();
		case ($urandom_range(4))
			0, 1:    return table_sb.find_busy_id();
			2, 3:    return $urandom_range(1, ID_LIMIT);
			default: return $urandom_range(0, ID_FIELD_MAX);
		endcase
	endfunction

	// Fill mode leans hard on allocation so the table gets full within the run;
	// churn mode mixes frees and allocations to punch holes and refill them.
	function automatic req_t next_command(bit churn);
		req_t item;
		int   roll;
		int   alloc_pct;
		int   close_pct;
		int   check_pct;
		roll      = $urandom_range(99);
		alloc_pct = churn ? 40 : 97;
		close_pct = churn ? 70 : 98;
		check_pct = churn ? 90 : 99;
		if (roll < alloc_pct) begin
			item.cmd      = CMD_OPEN;
			item.event_id = '0;
		end else if (roll < close_pct) begin
			item.cmd      = CMD_CLOSE;
			item.event_id = ID_W'(random_event_id());
		end else if (roll < check_pct) begin
			case ($urandom_range(2))
				0:       item.cmd = CMD_OPEN;
				1:       item.cmd = CMD_WAIT;
				default: item.cmd = CMD_SIGNAL;
			endcase
			item.event_id = ID_W'(random_event_id());
		end else begin
			item.cmd      = cmd_t'($urandom_range(3));
			item.event_id = ID_W'($urandom_range(0, ID_FIELD_MAX));
		end
		return item;
	endfunction

	// Reply side: takes and checks replies, stalls at random, and serves hold-off
	// requests by counting cycles here so the sender keeps pushing meanwhile.
	initial begin : reply_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
				table_sb.check_reply(rsp);
			if (hold_left == 0 && hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int random_items;
		int churn_items;
		table_sb     = new();
		random_items = 0;
		churn_items  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: lookups on an empty table, first allocations, reuse of the
		// lowest hole, id zero on every command, top id, above-range and all-ones ids
		issue(CMD_WAIT, 1);
		issue(CMD_OPEN, 0);
		issue(CMD_OPEN, 0);
		issue(CMD_OPEN, 0);
		issue(CMD_OPEN, 2);
		issue(CMD_WAIT, 1);
		issue(CMD_SIGNAL, 3);
		issue(CMD_CLOSE, 2);
		issue(CMD_CLOSE, 2);          // already free: must fail
		issue(CMD_OPEN, 0);           // refills id 2
		issue(CMD_CLOSE, 0);
		issue(CMD_WAIT, 0);
		issue(CMD_SIGNAL, 0);
		issue(CMD_OPEN, ID_LIMIT);
		issue(CMD_SIGNAL, ID_LIMIT + 1);
		issue(CMD_CLOSE, ID_FIELD_MAX);
		issue(CMD_WAIT, ID_FIELD_MAX);
		issue(CMD_OPEN, ID_FIELD_MAX);
		issue(CMD_OPEN, 0);
		issue(CMD_CLOSE, 1);
		issue(CMD_OPEN, 0);           // lowest free is 1 again

		// random: phase one sender idles lightly and replies stall often, phase
		// two swaps that, phase three runs flat out; drained between phases
		while (random_items < RANDOM_ITEMS || churn_items < CHURN_ITEMS) begin
			if (random_items == 400) begin
				wait_for_drain();
				req_idle_pct = 53;
				rsp_idle_pct = 17;
			end else if (random_items == 800) begin
				wait_for_drain();
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			// long reply hold-offs so the request side backs up behind them
			if (random_items == 150 || random_items == 900)
				hold_request = 400;
			if (table_sb.table_filled)
				churn_items++;
			send_command(next_command(table_sb.table_filled));
			random_items++;
		end

		wait_for_drain();
		// allow for the worst allocation scan; give any stray reply time to show
		repeat (40) @(posedge clk);
		table_sb.check_leftovers();
		if (table_sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hdl/lfia_pkg.sv
hdl/lfia_word_unit.sv
hdl/lowest_free_id_allocator_core.sv
sim/lowest_free_id_allocator_core_test.sv
